// ===== sv/efr_pkg.sv =====
package efr_pkg;

  localparam int NUM_ENCODERS = 12;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] HDR_LAST = 3'd5;
  localparam logic [7:0] HDR_FIRST_BYTE = 8'hAA;

  localparam logic [6:0] FRAME_LEN  = 7'd79;
  localparam logic [6:0] POS_FIRST  = 7'd6;
  localparam logic [6:0] POS_CRC_HI = FRAME_LEN - 7'd2;
  localparam logic [6:0] POS_CRC_LO = FRAME_LEN - 7'd1;

  localparam logic [3:0] ENC_SLOTS = 4'd12;
  localparam logic [3:0] ENC_LAST  = 4'(NUM_ENCODERS - 1);
  localparam logic [3:0] IDX_GRIP0 = 4'd12;
  localparam logic [3:0] IDX_MODE  = 4'd15;

  localparam logic [2:0] PH_ENC_LAST  = 3'd4;
  localparam logic [2:0] PH_GRIP_LAST = 3'd2;
  localparam logic [2:0] PH_MODE_LAST = 3'd1;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_FAIL  = 1'b1;

  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_BODY,
    ST_EMIT
  } efr_state_t;

  typedef struct packed {
    logic hunt_step;
    logic body_step;
    logic fail_load;
    logic emit_load;
    logic restart;
  } efr_cmd_t;

  typedef struct packed {
    logic hdr_complete;
    logic body_end;
    logic crc_match;
    logic out_free;
    logic emit_last;
  } efr_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'hAA;
      3'd1: b = 8'h55;
      3'd2: b = 8'h01;
      3'd3: b = 8'h4B;
      3'd4: b = 8'h41;
      3'd5: b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/efr_byte_if.sv =====
interface efr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/efr_result_if.sv =====
interface efr_result_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         value_index;
  logic signed [31:0] value;
  logic [30:0]        error_total;
  logic               last;

  modport source (output valid, output kind, output value_index, output value,
                  output error_total, output last, input ready);
  modport sink (input valid, input kind, input value_index, input value,
                input error_total, input last, output ready);
endinterface

// ===== sv/efr_ctrl.sv =====
module efr_ctrl
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  efr_stat_t  stat,
  output efr_cmd_t   cmd,
  output efr_state_t state
);

  efr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_HUNT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.hunt_step = 1'b1;
          if (stat.hdr_complete) begin
            state_next = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        in_ready = !stat.body_end || stat.out_free;
        if (in_valid && in_ready) begin
          if (stat.body_end) begin
            cmd.restart = 1'b1;
            if (stat.crc_match) begin
              state_next = ST_EMIT;
            end else begin
              cmd.fail_load = 1'b1;
              state_next    = ST_HUNT;
            end
          end else begin
            cmd.body_step = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

endmodule

// ===== sv/efr_datapath.sv =====
module efr_datapath
  import efr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    rx_byte,
  input  efr_cmd_t      cmd,
  output efr_stat_t     stat,
  efr_result_if.source  res
);

  logic [2:0]  header_matched;
  logic [6:0]  byte_position;
  logic [15:0] running_crc;
  logic [7:0]  crc_high_held;
  logic [23:0] acc;
  logic [31:0] value_store [16];
  logic [2:0]  phase;
  logic [3:0]  entry;
  logic [2:0]  phase_last;
  logic [30:0] failure_count;
  logic [30:0] count_inc;
  logic [3:0]  emit_idx;
  logic [31:0] emit_word;
  logic [31:0] emit_value;
  logic        out_valid;
  logic        byte_hit;

  assign byte_hit  = (rx_byte == hdr_byte(header_matched));
  assign count_inc = (failure_count == COUNT_MAX) ? failure_count : failure_count + 31'd1;

  assign stat.hdr_complete = (header_matched == HDR_LAST) && byte_hit;
  assign stat.body_end     = (byte_position == POS_CRC_LO);
  assign stat.crc_match    = ({crc_high_held, rx_byte} == running_crc);
  assign stat.out_free     = !out_valid || res.ready;
  assign stat.emit_last    = (emit_idx == IDX_MODE);

  always_comb begin
    if (entry < ENC_SLOTS) begin
      phase_last = PH_ENC_LAST;
    end else if (entry < IDX_MODE) begin
      phase_last = PH_GRIP_LAST;
    end else begin
      phase_last = PH_MODE_LAST;
    end
  end

  always_comb begin
    emit_word = value_store[emit_idx];
    if (emit_idx < IDX_GRIP0) begin
      emit_value = emit_word;
    end else if (emit_idx < IDX_MODE) begin
      emit_value = {{16{emit_word[15]}}, emit_word[15:0]};
    end else begin
      emit_value = {24'h000000, emit_word[7:0]};
    end
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      header_matched <= '0;
      byte_position  <= POS_FIRST;
      running_crc    <= CRC_INIT;
      phase          <= '0;
      entry          <= '0;
      emit_idx       <= '0;
    end else begin
      if (cmd.hunt_step) begin
        if (byte_hit) begin
          running_crc    <= crc16_byte(running_crc, rx_byte);
          header_matched <= (header_matched == HDR_LAST) ? '0 : header_matched + 3'd1;
        end else if (rx_byte == HDR_FIRST_BYTE) begin
          running_crc    <= crc16_byte(CRC_INIT, rx_byte);
          header_matched <= 3'd1;
        end else begin
          running_crc    <= CRC_INIT;
          header_matched <= '0;
        end
      end
      if (cmd.body_step) begin
        byte_position <= byte_position + 7'd1;
        if (byte_position < POS_CRC_HI) begin
          running_crc <= crc16_byte(running_crc, rx_byte);
          if (phase == phase_last) begin
            phase <= '0;
            entry <= entry + 4'd1;
          end else begin
            phase <= phase + 3'd1;
          end
        end
      end
      if (cmd.emit_load) begin
        emit_idx <= (emit_idx == ENC_LAST) ? IDX_GRIP0 : emit_idx + 4'd1;
      end
    end
  end

  // captured bytes
  always_ff @(posedge clk) begin
    if (cmd.body_step) begin
      if (byte_position < POS_CRC_HI) begin
        acc <= {acc[15:0], rx_byte};
        if (phase != 3'd0) begin
          value_store[entry] <= {acc, rx_byte};
        end
      end else begin
        crc_high_held <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_count <= '0;
    end else if (cmd.fail_load) begin
      failure_count <= count_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fail_load || cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fail_load) begin
      res.kind        <= KIND_FAIL;
      res.value_index <= '0;
      res.value       <= '0;
      res.error_total <= count_inc;
      res.last        <= 1'b1;
    end else if (cmd.emit_load) begin
      res.kind        <= KIND_VALUE;
      res.value_index <= emit_idx;
      res.value       <= emit_value;
      res.error_total <= failure_count;
      res.last        <= stat.emit_last;
    end
  end

  assign res.valid = out_valid;

endmodule

// ===== sv/encoder_frame_receiver_crc16_top.sv =====
// channel  dir  payload                                        per beat
// rx       in   rx_byte[7:0]                                   one serial byte
// res      out  kind, value_index[3:0], value[31:0] signed,    one result
//               error_total[30:0], last
//
// one byte per cycle while hunting for the header and capturing the frame
// a good frame yields a burst of NUM_ENCODERS + 4 results, one per cycle while res is ready, rx held off
// a bad frame yields one failure beat when its last byte is taken
// rx stalls on the final frame byte until the output register is free
// synchronous reset clears the hunt state and the failure count
module encoder_frame_receiver_crc16_top
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  efr_byte_if.sink    rx,
  efr_result_if.source res
);

  efr_cmd_t   cmd;
  efr_stat_t  stat;
  efr_state_t state;
  logic       in_ready;

  assign rx.ready = in_ready;

  efr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  efr_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

  a_fail_beat: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == KIND_FAIL) |->
      res.last && (res.value == 0) && (res.value_index == 4'd0))
    else $error("failure beat malformed");

  a_mode_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == KIND_VALUE) |->
      (res.last == (res.value_index == IDX_MODE)))
    else $error("last flag out of place in burst");

  a_mode_width: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == KIND_VALUE) && (res.value_index == IDX_MODE) |->
      (res.value[31:8] == 24'h000000))
    else $error("mode value not zero-extended");

  a_no_rx_in_burst: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !rx.ready)
    else $error("byte taken during result burst");

endmodule
